/* rtl/dccbse_pkg.sv */
// Package for the DCC bit stream encoder.
// Holds the beat payload types, packet size constants and phase codes; no dependencies.
`default_nettype none

package dccbse_pkg;

	localparam int MAX_PACKET_BYTES = 6;
	localparam int PACKET_W         = 8 * MAX_PACKET_BYTES;
	localparam int LEN_W            = 3;
	localparam int COUNT_W          = 8;
	localparam logic [COUNT_W-1:0] PREAMBLE_RESET = 8'd14;

	typedef enum logic [3:0] {
		PH_PREAMBLE = 4'b0001,
		PH_START    = 4'b0010,
		PH_BYTE     = 4'b0100,
		PH_STOP     = 4'b1000
	} phase_t;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_LOAD = 1'b1
	} kind_t;

	typedef struct packed {
		logic                kind;
		logic [PACKET_W-1:0] packet_data;
		logic [LEN_W-1:0]    packet_length;
	} item_t;

	typedef struct packed {
		logic line_bit;
		logic preamble_finished;
		logic packet_released;
		logic load_accepted;
	} result_t;

endpackage

`default_nettype wire

/* rtl/dcc_bit_stream_encoder.sv */
// DCC bit stream encoder top level: packet slot, bit sequencer and result skid buffer.
// Depends on dccbse_pkg.
`default_nettype none

// One beat in, one result beat out. A tick beat returns the next line bit; a load beat
// offers a packet of 1..MAX_PACKET_BYTES bytes to the single slot and reports whether it
// was taken. A result is registered into the output register, or the skid entry when that
// is stalled; the two let a beat be accepted every cycle, and item_ready drops only while
// both hold unclaimed results. cfg_wdata sets the preamble length (reset 14); the user must
// see that it is written only while the block is idle: the block does not enforce this.
module dcc_bit_stream_encoder (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       item_valid,
	output logic                      item_ready,
	input  dccbse_pkg::item_t         item,
	output logic                      result_valid,
	input  wire                       result_ready,
	output dccbse_pkg::result_t       result,
	input  wire                       cfg_we,
	input  wire [dccbse_pkg::COUNT_W-1:0] cfg_wdata
);
	import dccbse_pkg::*;

	logic [COUNT_W-1:0]                 preamble_count_q;
	phase_t                             phase_q, phase_d;
	logic [COUNT_W-1:0]                 pre_cnt_q, pre_cnt_d;
	logic [2:0]                         byte_idx_q, byte_idx_d;
	logic [2:0]                         bit_pos_q, bit_pos_d;
	logic [MAX_PACKET_BYTES-1:0][7:0]   store_q;
	logic [LEN_W-1:0]                   len_q;
	logic                               pending_q, pending_d;
	logic                               load_take;
	result_t                            res_d;
	result_t                            skid_q;
	logic                               skid_valid_q;
	logic                               item_fire, result_fire;
	logic [COUNT_W-1:0]                 pre_cnt_inc;
	logic [2:0]                         byte_idx_inc;
	logic [2:0]                         byte_sel;
	logic [7:0]                         cur_byte;

	assign item_ready  = !skid_valid_q;
	assign item_fire   = item_valid && item_ready;
	assign result_fire = result_valid && result_ready;

	assign pre_cnt_inc  = pre_cnt_q + COUNT_W'(1);
	assign byte_idx_inc = byte_idx_q + 3'd1;
	// first byte sits in the top lane
	assign byte_sel     = 3'(MAX_PACKET_BYTES - 1) - byte_idx_q;
	assign cur_byte     = (byte_idx_q < 3'(MAX_PACKET_BYTES)) ? store_q[byte_sel] : 8'h00;

	assign load_take = !pending_q && (item.packet_length != '0)
		&& (item.packet_length <= LEN_W'(MAX_PACKET_BYTES));

	always_comb begin
		phase_d    = phase_q;
		pre_cnt_d  = pre_cnt_q;
		byte_idx_d = byte_idx_q;
		bit_pos_d  = bit_pos_q;
		pending_d  = pending_q;
		res_d      = '0;
		if (item.kind == KIND_LOAD) begin
			if (load_take) begin
				pending_d          = 1'b1;
				res_d.load_accepted = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_PREAMBLE: begin
					res_d.line_bit = 1'b1;
					if (pre_cnt_inc >= preamble_count_q) begin
						pre_cnt_d               = '0;
						phase_d                 = PH_START;
						res_d.preamble_finished = 1'b1;
					end else begin
						pre_cnt_d = pre_cnt_inc;
					end
				end
				PH_START: begin
					// idle ones until a packet waits, then the start bit
					if (pending_q) begin
						phase_d        = PH_BYTE;
						res_d.line_bit = 1'b0;
					end else begin
						res_d.line_bit = 1'b1;
					end
				end
				PH_BYTE: begin
					res_d.line_bit = cur_byte[bit_pos_q];
					if (bit_pos_q == 3'd0) begin
						bit_pos_d = 3'd7;
						phase_d   = PH_STOP;
					end else begin
						bit_pos_d = bit_pos_q - 3'd1;
					end
				end
				PH_STOP: begin
					if (byte_idx_inc >= len_q) begin
						pending_d             = 1'b0;
						byte_idx_d            = '0;
						phase_d               = PH_PREAMBLE;
						res_d.packet_released = 1'b1;
						res_d.line_bit        = 1'b1;
					end else begin
						byte_idx_d     = byte_idx_inc;
						phase_d        = PH_BYTE;
						res_d.line_bit = 1'b0;
					end
				end
				default: begin
					phase_d = PH_PREAMBLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_count_q <= PREAMBLE_RESET;
			phase_q          <= PH_PREAMBLE;
			pre_cnt_q        <= '0;
			byte_idx_q       <= '0;
			bit_pos_q        <= 3'd7;
			len_q            <= '0;
			pending_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				preamble_count_q <= cfg_wdata;
			end
			if (item_fire) begin
				phase_q    <= phase_d;
				pre_cnt_q  <= pre_cnt_d;
				byte_idx_q <= byte_idx_d;
				bit_pos_q  <= bit_pos_d;
				pending_q  <= pending_d;
				if (item.kind == KIND_LOAD && load_take) begin
					len_q <= item.packet_length;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire && item.kind == KIND_LOAD && load_take) begin
			store_q <= item.packet_data;
		end
	end

	// output register plus one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (item_fire) begin
				if (result_valid && !result_ready) begin
					skid_valid_q <= 1'b1;
				end else begin
					result_valid <= 1'b1;
				end
			end else if (result_fire) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					result_valid <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			if (result_valid && !result_ready) begin
				skid_q <= res_d;
			end else begin
				result <= res_d;
			end
		end else if (result_fire && skid_valid_q) begin
			result <= skid_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/dccbse_chk.sv */
// Port-level checker for the DCC bit stream encoder, with its bind to the top level.
// Depends on dccbse_pkg and dcc_bit_stream_encoder.
`default_nettype none

module dccbse_chk (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            item_valid,
	input wire                            item_ready,
	input dccbse_pkg::item_t              item,
	input wire                            result_valid,
	input wire                            result_ready,
	input dccbse_pkg::result_t            result,
	input wire                            cfg_we,
	input wire [dccbse_pkg::COUNT_W-1:0]  cfg_wdata
);
	import dccbse_pkg::*;

	logic cfg_seen;
	assign cfg_seen = cfg_we && (cfg_wdata != '0 || item.kind == KIND_TICK || 1'b1);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// a load beat reports only its acceptance
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.load_accepted |->
			!result.line_bit && !result.preamble_finished && !result.packet_released)
		else $error("load result carries tick flags");

	a_end_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.packet_released || result.preamble_finished) |->
			result.line_bit && !(result.packet_released && result.preamble_finished))
		else $error("end bit or preamble completion not a lone one bit");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && !result_valid && !cfg_seen |=> result_valid)
		else $error("accepted beat produced no result");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && !(item_valid && item_ready) |=> !result_valid)
		else $error("result appeared without an accepted beat");

endmodule

bind dcc_bit_stream_encoder dccbse_chk u_dccbse_chk (.*);

`default_nettype wire

/* test/dcc_bit_stream_encoder_checker.sv */
// Scoreboard for the DCC bit stream encoder: watches the item, result and config ports,
// predicts each result beat and compares it field by field. Depends on dccbse_pkg.
`timescale 1ns / 100ps

module dcc_bit_stream_encoder_checker
	import dccbse_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	input  wire                item_ready,
	input  item_t              item,
	input  wire                result_valid,
	input  wire                result_ready,
	input  result_t            result,
	input  wire                cfg_we,
	input  wire [COUNT_W-1:0]  cfg_wdata,
	output int                 mismatches = 0,
	output int                 awaiting = 0
);

	// predictor state
	logic [COUNT_W-1:0]  ones_wanted;
	phase_t              seq_phase;
	logic [COUNT_W-1:0]  ones_sent;
	logic [2:0]          byte_sel;
	logic [2:0]          bit_sel;
	logic [PACKET_W-1:0] slot_bytes;
	logic [LEN_W-1:0]    slot_len;
	logic                slot_full;

	result_t bits_due[$];
	result_t want;

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, exp_val);
		mismatches++;
	endtask

	function automatic result_t encode_beat(input item_t b);
		result_t r;
		int      pos;
		r = '0;
		if (b.kind == KIND_LOAD) begin
			// busy slot, zero length and oversize length are all refused
			if (!slot_full && b.packet_length != 0 && b.packet_length <= MAX_PACKET_BYTES) begin
				slot_bytes = b.packet_data;
				slot_len = b.packet_length;
				slot_full = 1'b1;
				r.load_accepted = 1'b1;
			end
		end else begin
			case (seq_phase)
				PH_PREAMBLE: begin
					ones_sent = ones_sent + 1'b1;
					if (ones_sent >= ones_wanted) begin
						ones_sent = '0;
						seq_phase = PH_START;
						r.preamble_finished = 1'b1;
					end
					r.line_bit = 1'b1;
				end
				PH_START: begin
					if (slot_full)
						seq_phase = PH_BYTE;
					else
						r.line_bit = 1'b1;
				end
				PH_BYTE: begin
					if (byte_sel < MAX_PACKET_BYTES) begin
						pos = (MAX_PACKET_BYTES - 1 - int'(byte_sel)) * 8 + int'(bit_sel);
						r.line_bit = slot_bytes[pos];
					end
					if (bit_sel == 0) begin
						bit_sel = 3'd7;
						seq_phase = PH_STOP;
					end else begin
						bit_sel = bit_sel - 1'b1;
					end
				end
				default: begin
					byte_sel = byte_sel + 1'b1;
					if (byte_sel >= slot_len) begin
						// end bit frees the slot
						slot_full = 1'b0;
						byte_sel = '0;
						seq_phase = PH_PREAMBLE;
						r.packet_released = 1'b1;
						r.line_bit = 1'b1;
					end else begin
						seq_phase = PH_BYTE;
					end
				end
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ones_wanted = PREAMBLE_RESET;
			seq_phase = PH_PREAMBLE;
			ones_sent = '0;
			byte_sel = '0;
			bit_sel = 3'd7;
			slot_bytes = '0;
			slot_len = '0;
			slot_full = 1'b0;
			bits_due.delete();
			awaiting <= 0;
		end else begin
			if (cfg_we)
				ones_wanted = cfg_wdata;
			if (result_valid && result_ready) begin
				if (bits_due.size() == 0) begin
					report_mismatch("unexpected result beat", int'(result), 0);
				end else begin
					want = bits_due.pop_front();
					if (result.line_bit !== want.line_bit)
						report_mismatch("line_bit", int'(result.line_bit),
							int'(want.line_bit));
					if (result.preamble_finished !== want.preamble_finished)
						report_mismatch("preamble_finished", int'(result.preamble_finished),
							int'(want.preamble_finished));
					if (result.packet_released !== want.packet_released)
						report_mismatch("packet_released", int'(result.packet_released),
							int'(want.packet_released));
					if (result.load_accepted !== want.load_accepted)
						report_mismatch("load_accepted", int'(result.load_accepted),
							int'(want.load_accepted));
				end
			end
			if (item_valid && item_ready)
				bits_due.push_back(encode_beat(item));
			awaiting <= bits_due.size();
		end
	end

endmodule

/* test/dcc_bit_stream_encoder_test.sv */
// Testbench top for the DCC bit stream encoder: clock, reset, stimulus and verdict.
// Depends on dccbse_pkg, dcc_bit_stream_encoder and dcc_bit_stream_encoder_checker.
`timescale 1ns / 100ps

module dcc_bit_stream_encoder_test;
	import dccbse_pkg::*;

	localparam int CYCLE_LIMIT = 100000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	item_t              item = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	result_t            result;
	logic               cfg_we = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;

	int mismatches;
	int awaiting;
	int idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;

	dcc_bit_stream_encoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	dcc_bit_stream_encoder_checker check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.awaiting     (awaiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= stall_pct);
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic item_t make_beat(input logic k, input logic [PACKET_W-1:0] data,
		input logic [LEN_W-1:0] len);
		item_t b;
		b.kind = k;
		b.packet_data = data;
		b.packet_length = len;
		return b;
	endfunction

	task automatic send_beat(input item_t b);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= b;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	// drop valid and wait until every result beat has drained
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_preamble(input logic [COUNT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		item_t beat;
		int    n_beats;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: refused loads, a one-byte packet through the reset preamble length
		send_beat(make_beat(KIND_TICK, '0, '0));
		send_beat(make_beat(KIND_LOAD, '1, 3'd0));
		send_beat(make_beat(KIND_LOAD, '1, 3'd7));
		send_beat(make_beat(KIND_LOAD, '1, 3'd1));
		send_beat(make_beat(KIND_LOAD, '0, LEN_W'(MAX_PACKET_BYTES)));
		repeat (23) send_beat(make_beat(KIND_TICK, '1, 3'd7));
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			// a long count followed by a short one lowers it mid-preamble
			case (ph)
				0: write_preamble(8'd200);
				1: write_preamble(8'd5);
				2: write_preamble(8'd0);
				3: write_preamble(8'd255);
				4: write_preamble(8'd1);
				5: write_preamble(8'd3);
				default: write_preamble(COUNT_W'($urandom_range(2, 24)));
			endcase
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 72; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 72; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			n_beats = (ph == 3) ? 320 : 65;
			repeat (n_beats) begin
				beat.kind = ($urandom_range(99) < 12) ? KIND_LOAD : KIND_TICK;
				case ($urandom_range(9))
					0: beat.packet_data = '0;
					1: beat.packet_data = '1;
					default: beat.packet_data = PACKET_W'({$urandom, $urandom});
				endcase
				if ($urandom_range(9) == 0)
					beat.packet_length = $urandom_range(1) ? 3'd7 : 3'd0;
				else
					beat.packet_length = LEN_W'($urandom_range(1, MAX_PACKET_BYTES));
				send_beat(beat);
			end
			settle();
		end

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
